/* design/assert_macros.svh */
// assertion macros shared by the shaper rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
`define ASSERT_NEVER(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, prop)
`endif
`endif

/* design/ishs_pkg.sv */
// shared types, constants and helpers for the injection shaper
`timescale 1ns / 1ps
package ishs_pkg;

  localparam int SLOTS_PER_CLUSTER = 6;
  localparam int MAX_DEST = 64;
  localparam int DEST_W = $clog2(MAX_DEST);
  localparam int CNT_W = DEST_W + 1;
  localparam int OPND_W = 64;
  localparam int DIV_W = 8;
  localparam int DIGIT_W = 4;

  localparam logic [7:0] PHASE_MASK0 = 8'b0000_1111;
  localparam logic [7:0] PHASE_MASK1 = 8'b0011_1100;
  localparam logic [7:0] PHASE_MASK2 = 8'b0011_0011;

  localparam logic [1:0] MODE_SKIP = 2'd0;
  localparam logic [1:0] MODE_TDM = 2'd1;
  localparam logic [1:0] MODE_RATE = 2'd2;

  localparam logic ITEM_TICK = 1'b0;
  localparam logic ITEM_GRANT = 1'b1;

  localparam logic CHAN_REQ = 1'b0;
  localparam logic CHAN_RSP = 1'b1;

  localparam logic [2:0] REG_SHAPER_MODE = 3'd0;
  localparam logic [2:0] REG_SKIP_PERIOD = 3'd1;
  localparam logic [2:0] REG_SKIP_INDEX = 3'd2;
  localparam logic [2:0] REG_TDM_SLOT = 3'd3;
  localparam logic [2:0] REG_RATE_INCREMENT = 3'd4;
  localparam logic [2:0] REG_RESPONSE_PRIORITY_ON = 3'd5;
  localparam logic [2:0] REG_RESPONSE_BOUND = 3'd6;
  localparam logic [2:0] REG_DEST_COUNT = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CYC,
    S_IDX,
    S_PTR0,
    S_PTR1,
    S_PICK,
    S_GRANT,
    S_GDONE
  } state_t;

  // control of the shared remainder unit
  typedef struct packed {
    logic              load;
    logic              step;
    logic [OPND_W-1:0] operand;
    logic [DIV_W-1:0]  divisor;
  } rem_ctrl_t;

  typedef struct packed {
    logic              has_head;
    logic              channel;
    logic [DEST_W-1:0] dest;
  } pick_t;

  // lowest set bit: {found, index}
  function automatic logic [DEST_W:0] find_first(input logic [MAX_DEST-1:0] v);
    logic [DEST_W:0] res;
    res = '0;
    for (int i = MAX_DEST - 1; i >= 0; i--) begin
      if (v[i]) begin
        res = {1'b1, DEST_W'(i)};
      end
    end
    return res;
  endfunction

  function automatic logic phase_bit(input logic [1:0] phase, input logic [2:0] slot);
    logic [7:0] m;
    case (phase)
      2'd0: m = PHASE_MASK0;
      2'd1: m = PHASE_MASK1;
      2'd2: m = PHASE_MASK2;
      default: m = '0;
    endcase
    return m[slot];
  endfunction

endpackage

/* design/ishs_rem.sv */
// radix-16 remainder unit, one hex digit of the operand per step
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ishs_rem import ishs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  rem_ctrl_t        ctl,
  output logic [DIV_W-1:0] rem_next
);

  localparam int X_W = DIV_W + DIGIT_W;
  localparam int QMAX = (1 << DIGIT_W) - 1;

  logic [OPND_W-1:0] opnd;
  logic [DIV_W-1:0]  div_r;
  logic [DIV_W-1:0]  rem_r;
  logic [X_W-1:0]    x;
  logic [X_W-1:0]    rfull;

  // x < 16 * divisor, so the quotient digit is the largest k with k * d <= x
  always_comb begin
    x = {rem_r, opnd[OPND_W-1 -: DIGIT_W]};
    rfull = x;
    for (int k = 1; k <= QMAX; k++) begin
      if (x >= X_W'(k) * X_W'(div_r)) begin
        rfull = x - X_W'(k) * X_W'(div_r);
      end
    end
    rem_next = rfull[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem_r <= '0;
      div_r <= DIV_W'(1);
    end else if (ctl.load) begin
      rem_r <= '0;
      div_r <= ctl.divisor;
    end else if (ctl.step) begin
      rem_r <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      opnd <= ctl.operand;
    end else if (ctl.step) begin
      opnd <= {opnd[OPND_W-DIGIT_W-1:0], DIGIT_W'(0)};
    end
  end

  `ASSERT_ALWAYS(a_rem_below_div, clk, rst, rem_r < div_r)
  `ASSERT_NEVER(a_div_zero, clk, rst, div_r == '0)
  `ASSERT_ALWAYS(a_load_clears, clk, rst, ctl.load |=> rem_r == '0)

endmodule

/* design/ishs_pick.sv */
// head selection: channel choice and rotating destination search
`timescale 1ns / 1ps
module ishs_pick import ishs_pkg::*; (
  input  logic [MAX_DEST-1:0] req_mask,
  input  logic [MAX_DEST-1:0] rsp_mask,
  input  logic [DEST_W-1:0]   start_req,
  input  logic [DEST_W-1:0]   start_rsp,
  input  logic [CNT_W-1:0]    count,
  input  logic                prio_on,
  input  logic [7:0]          bound,
  input  logic [7:0]          consec,
  output pick_t               pick
);

  logic [MAX_DEST-1:0] lim;
  logic [MAX_DEST-1:0] req_m;
  logic [MAX_DEST-1:0] rsp_m;
  logic [DEST_W:0]     req_hi;
  logic [DEST_W:0]     req_any;
  logic [DEST_W:0]     rsp_hi;
  logic [DEST_W:0]     rsp_any;
  logic                hq;
  logic                hr;
  logic [DEST_W-1:0]   dq;
  logic [DEST_W-1:0]   dr;

  always_comb begin
    // bits at or above the count do not take part
    if (count[CNT_W-1]) begin
      lim = '1;
    end else begin
      lim = (MAX_DEST'(1) << count[DEST_W-1:0]) - MAX_DEST'(1);
    end
    req_m = req_mask & lim;
    rsp_m = rsp_mask & lim;
    // search from the start point upward first, then wrap to the bottom
    req_hi = find_first(req_m & ~((MAX_DEST'(1) << start_req) - MAX_DEST'(1)));
    req_any = find_first(req_m);
    rsp_hi = find_first(rsp_m & ~((MAX_DEST'(1) << start_rsp) - MAX_DEST'(1)));
    rsp_any = find_first(rsp_m);
    hq = req_any[DEST_W];
    hr = rsp_any[DEST_W];
    dq = req_hi[DEST_W] ? req_hi[DEST_W-1:0] : req_any[DEST_W-1:0];
    dr = rsp_hi[DEST_W] ? rsp_hi[DEST_W-1:0] : rsp_any[DEST_W-1:0];

    pick.has_head = hq | hr;
    if (prio_on) begin
      if (hr && consec < bound) begin
        pick.channel = CHAN_RSP;
      end else if (hq) begin
        pick.channel = CHAN_REQ;
      end else begin
        pick.channel = CHAN_RSP;
      end
    end else begin
      pick.channel = hq ? CHAN_REQ : CHAN_RSP;
    end
    if (!pick.has_head) begin
      pick.channel = CHAN_REQ;
    end
    pick.dest = (pick.channel == CHAN_RSP) ? dr : dq;
    if (!pick.has_head) begin
      pick.dest = '0;
    end
  end

endmodule

/* design/injection_shaper_head_select.sv */
// top level: shaper, sequencer, shared remainder unit and head selection
// tick transaction: 16 digits of the cycle, 2 of the index and 2 of each pointer pass
//   through the radix-16 remainder unit, then the pick state loads the output register
// grant transaction: 2 remainder steps, then the grant done state loads the output register
// one item at a time: in_stall is high while the sequencer is not idle, also while out_stall holds it
// rst is synchronous: registers take their defaults, pointers, counters and accumulator clear
`timescale 1ns / 1ps
`include "assert_macros.svh"
module injection_shaper_head_select import ishs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [63:0]         cycle_number,
  input  logic [MAX_DEST-1:0] request_waiting,
  input  logic [MAX_DEST-1:0] response_waiting,
  input  logic                grant_channel,
  input  logic [DEST_W-1:0]   grant_dest,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                eligible,
  output logic                has_head,
  output logic                pick_channel,
  output logic [DEST_W-1:0]   pick_dest
);

  // configuration registers
  logic [1:0]        shaper_mode;
  logic [7:0]        skip_period;
  logic [5:0]        skip_index;
  logic [2:0]        tdm_slot;
  logic [4:0]        rate_increment;
  logic              response_priority_on;
  logic [7:0]        response_bound;
  logic [CNT_W-1:0]  dest_count;

  // block state
  logic [5:0]        rate_accumulator;
  logic [DEST_W-1:0] dest_pointer [2];
  logic [7:0]        consec;

  state_t            state;
  state_t            state_next;
  logic [3:0]        step_cnt;
  logic [3:0]        cnt_init;
  logic              last_step;
  logic              in_accept;
  logic              out_free;
  logic              out_load;
  logic              grant_done;

  logic [MAX_DEST-1:0] req_r;
  logic [MAX_DEST-1:0] rsp_r;
  logic                grant_ch;
  logic [DIV_W-1:0]    rem_cyc;
  logic [DIV_W-1:0]    rem_idx;
  logic [DEST_W-1:0]   start0;
  logic [DEST_W-1:0]   start1;

  logic [CNT_W-1:0]  n_eff;
  logic [DIV_W-1:0]  p_eff;
  logic [DIV_W-1:0]  tick_div;
  logic [CNT_W-1:0]  gplus1;
  logic [6:0]        acc_sum;
  logic              rate_hit;
  logic [6:0]        acc_new;
  logic              elig;

  rem_ctrl_t         ctl;
  logic [DIV_W-1:0]  rem_next;
  pick_t             pick;

  assign in_stall = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last_step = (step_cnt == 4'd0);
  assign out_load = (state == S_PICK || state == S_GDONE) && out_free;
  assign grant_done = (state == S_GRANT) && last_step;

  always_comb begin
    if (dest_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (dest_count > CNT_W'(MAX_DEST)) begin
      n_eff = CNT_W'(MAX_DEST);
    end else begin
      n_eff = dest_count;
    end
    p_eff = (skip_period == '0) ? DIV_W'(3) : skip_period;
    tick_div = (shaper_mode == MODE_TDM) ? DIV_W'(3) : p_eff;
    gplus1 = CNT_W'(grant_dest) + CNT_W'(1);
  end

  // shaper decision, evaluated in the pick state
  always_comb begin
    acc_sum = 7'(rate_accumulator) + 7'(rate_increment);
    rate_hit = (acc_sum >= 7'(SLOTS_PER_CLUSTER));
    acc_new = rate_hit ? acc_sum - 7'(SLOTS_PER_CLUSTER) : acc_sum;
    unique case (shaper_mode)
      MODE_RATE: elig = rate_hit;
      MODE_TDM:  elig = phase_bit(rem_cyc[1:0], tdm_slot);
      default:   elig = (rem_cyc != rem_idx);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (mode == ITEM_GRANT) ? S_GRANT : S_CYC;
        end
      end
      S_CYC: begin
        if (last_step) state_next = S_IDX;
      end
      S_IDX: begin
        if (last_step) state_next = S_PTR0;
      end
      S_PTR0: begin
        if (last_step) state_next = S_PTR1;
      end
      S_PTR1: begin
        if (last_step) state_next = S_PICK;
      end
      S_PICK: begin
        if (out_free) state_next = S_IDLE;
      end
      S_GRANT: begin
        if (last_step) state_next = S_GDONE;
      end
      S_GDONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // remainder unit control: a load in the last step of one job starts the next
  always_comb begin
    ctl = '0;
    cnt_init = 4'd1;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          ctl.load = 1'b1;
          if (mode == ITEM_GRANT) begin
            ctl.operand = {1'b0, gplus1, (OPND_W - 8)'(0)};
            ctl.divisor = DIV_W'(n_eff);
          end else begin
            ctl.operand = cycle_number;
            ctl.divisor = tick_div;
            cnt_init = 4'd15;
          end
        end
      end
      S_CYC: begin
        ctl.step = 1'b1;
        ctl.load = last_step;
        ctl.operand = {2'b00, skip_index, (OPND_W - 8)'(0)};
        ctl.divisor = tick_div;
      end
      S_IDX: begin
        ctl.step = 1'b1;
        ctl.load = last_step;
        ctl.operand = {2'b00, dest_pointer[0], (OPND_W - 8)'(0)};
        ctl.divisor = DIV_W'(n_eff);
      end
      S_PTR0: begin
        ctl.step = 1'b1;
        ctl.load = last_step;
        ctl.operand = {2'b00, dest_pointer[1], (OPND_W - 8)'(0)};
        ctl.divisor = DIV_W'(n_eff);
      end
      S_PTR1, S_GRANT: begin
        ctl.step = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  ishs_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rem_next (rem_next)
  );

  ishs_pick u_pick (
    .req_mask  (req_r),
    .rsp_mask  (rsp_r),
    .start_req (start0),
    .start_rsp (start1),
    .count     (n_eff),
    .prio_on   (response_priority_on),
    .bound     (response_bound),
    .consec    (consec),
    .pick      (pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        step_cnt <= cnt_init;
      end else if (ctl.step) begin
        step_cnt <= step_cnt - 4'd1;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      shaper_mode <= MODE_SKIP;
      skip_period <= 8'd3;
      skip_index <= '0;
      tdm_slot <= '0;
      rate_increment <= 5'd4;
      response_priority_on <= 1'b1;
      response_bound <= 8'd4;
      dest_count <= CNT_W'(MAX_DEST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHAPER_MODE:          shaper_mode <= cfg_data[1:0];
        REG_SKIP_PERIOD:          skip_period <= cfg_data;
        REG_SKIP_INDEX:           skip_index <= cfg_data[5:0];
        REG_TDM_SLOT:             tdm_slot <= cfg_data[2:0];
        REG_RATE_INCREMENT:       rate_increment <= cfg_data[4:0];
        REG_RESPONSE_PRIORITY_ON: response_priority_on <= cfg_data[0];
        REG_RESPONSE_BOUND:       response_bound <= cfg_data;
        REG_DEST_COUNT:           dest_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // captured transaction payload and remainders
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= request_waiting;
      rsp_r <= response_waiting;
      grant_ch <= grant_channel;
    end
    if (state == S_CYC && last_step) rem_cyc <= rem_next;
    if (state == S_IDX && last_step) rem_idx <= rem_next;
    if (state == S_PTR0 && last_step) start0 <= rem_next[DEST_W-1:0];
    if (state == S_PTR1 && last_step) start1 <= rem_next[DEST_W-1:0];
  end

  // pointers, response run length and rate accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_accumulator <= '0;
      dest_pointer[0] <= '0;
      dest_pointer[1] <= '0;
      consec <= '0;
    end else begin
      if (grant_done) begin
        dest_pointer[grant_ch] <= rem_next[DEST_W-1:0];
        if (grant_ch == CHAN_RSP) begin
          if (consec != 8'd255) consec <= consec + 8'd1;
        end else begin
          consec <= '0;
        end
      end
      if (state == S_PICK && out_free && shaper_mode == MODE_RATE) begin
        rate_accumulator <= acc_new[5:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PICK && out_free) begin
      eligible <= elig;
      has_head <= elig & pick.has_head;
      pick_channel <= elig & pick.channel;
      pick_dest <= elig ? pick.dest : '0;
    end else if (state == S_GDONE && out_free) begin
      eligible <= 1'b0;
      has_head <= 1'b0;
      pick_channel <= CHAN_REQ;
      pick_dest <= '0;
    end
  end

  `ASSERT_ALWAYS(a_head_needs_elig, clk, rst, out_valid && has_head |-> eligible)
  `ASSERT_ALWAYS(a_out_source, clk, rst, $rose(out_valid) |-> $past(out_load))
  `ASSERT_ALWAYS(a_ptr_in_range, clk, rst, grant_done |=> CNT_W'(dest_pointer[grant_ch]) < n_eff)
  `ASSERT_ALWAYS(a_consec_sat, clk, rst, $past(consec) == 8'd255 |-> &consec || ~|consec)

endmodule

/* tb/injection_shaper_head_select_test.sv */
// self-checking testbench for the injection shaper and head selector
`timescale 1ns / 1ps
module injection_shaper_head_select_test;
  import ishs_pkg::*;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};
  localparam int HOLDOFF_CYCLES = 400;

  typedef struct {
    logic              mode;
    logic [63:0]       cyc;
    logic [63:0]       req;
    logic [63:0]       rsp;
    logic              gch;
    logic [DEST_W-1:0] gdst;
  } shaper_item_t;

  typedef struct {
    logic              elig;
    logic              head;
    logic              chan;
    logic [DEST_W-1:0] dest;
  } pick_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [7:0]          cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                mode = 1'b0;
  logic [63:0]         cycle_number = '0;
  logic [MAX_DEST-1:0] request_waiting = '0;
  logic [MAX_DEST-1:0] response_waiting = '0;
  logic                grant_channel = 1'b0;
  logic [DEST_W-1:0]   grant_dest = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                eligible;
  logic                has_head;
  logic                pick_channel;
  logic [DEST_W-1:0]   pick_dest;

  injection_shaper_head_select u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .cycle_number     (cycle_number),
    .request_waiting  (request_waiting),
    .response_waiting (response_waiting),
    .grant_channel    (grant_channel),
    .grant_dest       (grant_dest),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .eligible         (eligible),
    .has_head         (has_head),
    .pick_channel     (pick_channel),
    .pick_dest        (pick_dest)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register copies, reset values
  logic [1:0]        shaper_mode_r = MODE_SKIP;
  logic [7:0]        period_r = 8'd3;
  logic [5:0]        skip_index_r = 6'd0;
  logic [2:0]        slot_r = 3'd0;
  logic [4:0]        incr_r = 5'd4;
  logic              rsp_prio_r = 1'b1;
  logic [7:0]        rsp_bound_r = 8'd4;
  logic [6:0]        dest_count_r = 7'd64;

  // shaper and selector state
  logic [5:0]        rate_acc = '0;
  logic [DEST_W-1:0] next_dest [2] = '{default: '0};
  logic [7:0]        rsp_streak = '0;

  shaper_item_t issue_queue [$];
  pick_result_t expected_picks [$];
  shaper_item_t batch [$];

  shaper_item_t cur_item;
  logic offering = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int holdoff_left = 0;
  logic holdoff_request = 1'b0;
  int stall_style = 0;
  int recv_cycle = 0;

  int failures = 0;
  int ticks_sent = 0;
  int grants_sent = 0;
  int picks_checked = 0;
  int heads_seen = 0;
  int settings_used = 1;

  function automatic int active_dests();
    if (dest_count_r == 0) return 1;
    if (dest_count_r > MAX_DEST) return MAX_DEST;
    return int'(dest_count_r);
  endfunction

  // rotating search from start over the first n destinations
  function automatic logic scan_dests(input logic [63:0] mask, input int start, input int n,
                                      output logic [DEST_W-1:0] found);
    int d;
    found = '0;
    for (int k = 0; k < n; k++) begin
      d = (start + k) % n;
      if (mask[d]) begin
        found = DEST_W'(d);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic pick_result_t predict_pick(input shaper_item_t it);
    pick_result_t r;
    int n;
    int acc;
    logic [63:0] p;
    logic [7:0] pm;
    logic hq, hr;
    logic [DEST_W-1:0] dq, dr;
    r = '{elig: 1'b0, head: 1'b0, chan: CHAN_REQ, dest: '0};
    n = active_dests();
    if (it.mode == ITEM_GRANT) begin
      next_dest[it.gch] = DEST_W'((int'(it.gdst) + 1) % n);
      if (it.gch == CHAN_RSP) begin
        if (rsp_streak != 8'hFF) rsp_streak = rsp_streak + 8'd1;
      end else begin
        rsp_streak = '0;
      end
      return r;
    end
    case (shaper_mode_r)
      MODE_RATE: begin
        acc = int'(rate_acc) + int'(incr_r);
        if (acc >= SLOTS_PER_CLUSTER) begin
          r.elig = 1'b1;
          acc -= SLOTS_PER_CLUSTER;
        end
        rate_acc = acc[5:0];
      end
      MODE_TDM: begin
        case (it.cyc % 64'd3)
          64'd0: pm = PHASE_MASK0;
          64'd1: pm = PHASE_MASK1;
          default: pm = PHASE_MASK2;
        endcase
        r.elig = pm[slot_r];
      end
      default: begin
        // reserved mode falls back to skip modulo
        p = (period_r == 0) ? 64'd3 : 64'(period_r);
        r.elig = ((it.cyc % p) != (64'(skip_index_r) % p));
      end
    endcase
    if (r.elig) begin
      hq = scan_dests(it.req, int'(next_dest[CHAN_REQ]) % n, n, dq);
      hr = scan_dests(it.rsp, int'(next_dest[CHAN_RSP]) % n, n, dr);
      if (hq || hr) begin
        r.head = 1'b1;
        if (rsp_prio_r) r.chan = (hr && rsp_streak < rsp_bound_r) ? CHAN_RSP :
                                 (hq ? CHAN_REQ : CHAN_RSP);
        else r.chan = hq ? CHAN_REQ : CHAN_RSP;
        r.dest = (r.chan == CHAN_RSP) ? dr : dq;
      end
    end
    return r;
  endfunction

  function automatic shaper_item_t tick_item(input logic [63:0] cyc, input logic [63:0] req,
                                             input logic [63:0] rsp);
    shaper_item_t it;
    it.mode = ITEM_TICK;
    it.cyc = cyc;
    it.req = req;
    it.rsp = rsp;
    it.gch = 1'($urandom_range(0, 1));
    it.gdst = DEST_W'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic shaper_item_t grant_item(input logic ch, input logic [DEST_W-1:0] dst);
    shaper_item_t it;
    it.mode = ITEM_GRANT;
    it.cyc = {$urandom, $urandom};
    it.req = {$urandom, $urandom};
    it.rsp = {$urandom, $urandom};
    it.gch = ch;
    it.gdst = dst;
    return it;
  endfunction

  function automatic logic [63:0] rand_mask();
    logic [63:0] m;
    case ($urandom_range(0, 7))
      0: m = '0;
      1: m = ALL_ONES;
      2: m = 64'd1 << $urandom_range(0, 63);
      3: m = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
      4: m = {$urandom, $urandom} & {32'd0, 24'd0, 8'($urandom)};
      default: m = {$urandom, $urandom};
    endcase
    return m;
  endfunction

  function automatic logic [63:0] rand_cycle();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 1000));
      1: return ALL_ONES - 64'($urandom_range(0, 300));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [DEST_W-1:0] rand_dest();
    if ($urandom_range(0, 4) == 0) return DEST_W'($urandom_range(0, 63));
    return DEST_W'($urandom_range(0, active_dests() - 1));
  endfunction

  function automatic shaper_item_t random_item();
    if ($urandom_range(0, 2) == 0) return grant_item(1'($urandom_range(0, 1)), rand_dest());
    return tick_item(rand_cycle(), rand_mask(), rand_mask());
  endfunction

  // append one item to the batch being built
  function automatic void stage(input shaper_item_t it);
    batch.insert(batch.size(), it);
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SHAPER_MODE:          shaper_mode_r = val[1:0];
      REG_SKIP_PERIOD:          period_r = val;
      REG_SKIP_INDEX:           skip_index_r = val[5:0];
      REG_TDM_SLOT:             slot_r = val[2:0];
      REG_RATE_INCREMENT:       incr_r = val[4:0];
      REG_RESPONSE_PRIORITY_ON: rsp_prio_r = val[0];
      REG_RESPONSE_BOUND:       rsp_bound_r = val;
      default:                  dest_count_r = val[6:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic randomize_regs();
    logic [7:0] v;
    set_reg(REG_SHAPER_MODE, 8'($urandom_range(0, 3)));
    case ($urandom_range(0, 5))
      0: v = 8'd0;
      1: v = 8'd255;
      2: v = 8'd1;
      default: v = 8'($urandom_range(2, 9));
    endcase
    set_reg(REG_SKIP_PERIOD, v);
    set_reg(REG_SKIP_INDEX, 8'($urandom_range(0, 63)));
    set_reg(REG_TDM_SLOT, 8'($urandom_range(0, 7)));
    case ($urandom_range(0, 4))
      0: v = 8'd0;
      1: v = 8'd31;
      2: v = 8'd16;
      default: v = 8'($urandom_range(1, 16));
    endcase
    set_reg(REG_RATE_INCREMENT, v);
    set_reg(REG_RESPONSE_PRIORITY_ON, 8'($urandom_range(0, 1)));
    case ($urandom_range(0, 4))
      0: v = 8'd0;
      1: v = 8'd255;
      default: v = 8'($urandom_range(1, 6));
    endcase
    set_reg(REG_RESPONSE_BOUND, v);
    case ($urandom_range(0, 6))
      0: v = 8'd0;
      1: v = 8'd127;
      2: v = 8'd64;
      3: v = 8'd1;
      default: v = 8'($urandom_range(2, 20));
    endcase
    set_reg(REG_DEST_COUNT, v);
    settings_used++;
  endtask

  task automatic issue(inout shaper_item_t b [$]);
    @(negedge clk);
    foreach (b[i]) issue_queue.insert(issue_queue.size(), b[i]);
    b.delete();
  endtask

  // sender stays quiet until every expected pick has come back
  task automatic wait_idle();
    while (issue_queue.size() != 0 || offering || expected_picks.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end else begin
      if (offering && !in_stall) begin
        expected_picks.insert(expected_picks.size(), predict_pick(cur_item));
        if (cur_item.mode == ITEM_TICK) ticks_sent++;
        else grants_sent++;
        offering = 1'b0;
        if (burst_left > 0) burst_left--;
      end
      if (!offering) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (issue_queue.size() != 0) begin
          cur_item = issue_queue[0];
          issue_queue.delete(0);
          offering = 1'b1;
          mode <= cur_item.mode;
          cycle_number <= cur_item.cyc;
          request_waiting <= cur_item.req;
          response_waiting <= cur_item.rsp;
          grant_channel <= cur_item.gch;
          grant_dest <= cur_item.gdst;
        end
      end
      in_valid <= offering;
    end
  end

  // receiver: stall pattern re-drawn at random as recv_cycle runs, long holdoff on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      recv_cycle++;
      if (recv_cycle % 200 == 0) stall_style = $urandom_range(0, 3);
      if (holdoff_left == 0 && holdoff_request) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_request = 1'b0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= recv_cycle[2];
        endcase
      end
    end
  end

  pick_result_t want;

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (expected_picks.size() == 0) begin
        $error("result transaction with no pending expectation");
        failures++;
      end else begin
        want = expected_picks[0];
        expected_picks.delete(0);
        picks_checked++;
        if (want.head) heads_seen++;
        if (eligible !== want.elig) begin
          $error("eligible: expected %0d, got %0d", want.elig, eligible);
          failures++;
        end
        if (has_head !== want.head) begin
          $error("has_head: expected %0d, got %0d", want.head, has_head);
          failures++;
        end
        if (pick_channel !== want.chan) begin
          $error("pick_channel: expected %0d, got %0d", want.chan, pick_channel);
          failures++;
        end
        if (pick_dest !== want.dest) begin
          $error("pick_dest: expected %0d, got %0d", want.dest, pick_dest);
          failures++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int random_sent;
    int phase_len;
    int k;
    random_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: skip modulo, period 3, full rotation, response priority
    stage(tick_item(64'd0, ALL_ONES, ALL_ONES));
    stage(tick_item(64'd1, ALL_ONES, ALL_ONES));
    stage(tick_item(ALL_ONES, ALL_ONES, '0));
    stage(tick_item(64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0000, '0));
    stage(grant_item(CHAN_RSP, 6'd63));
    stage(grant_item(CHAN_REQ, 6'd5));
    stage(tick_item(64'd4, 64'h408, '0));
    stage(tick_item(64'd5, '0, '0));
    issue(batch);
    wait_idle();

    // slot table, slot past the table never eligible
    set_reg(REG_SHAPER_MODE, 8'(MODE_TDM));
    set_reg(REG_TDM_SLOT, 8'd7);
    stage(tick_item(64'd1, ALL_ONES, ALL_ONES));
    issue(batch);
    wait_idle();
    set_reg(REG_TDM_SLOT, 8'd5);
    for (int c = 0; c < 3; c++) stage(tick_item(64'(c), ALL_ONES, '0));
    issue(batch);
    wait_idle();

    // rate cap with the largest increment wraps the 6-bit accumulator
    set_reg(REG_SHAPER_MODE, 8'(MODE_RATE));
    set_reg(REG_RATE_INCREMENT, 8'd31);
    repeat (3) stage(tick_item(rand_cycle(), rand_mask(), rand_mask()));
    issue(batch);
    wait_idle();
    set_reg(REG_RATE_INCREMENT, 8'd0);
    repeat (2) stage(tick_item(rand_cycle(), ALL_ONES, ALL_ONES));
    issue(batch);
    wait_idle();

    // reserved mode, zero period, zero destination count
    set_reg(REG_SHAPER_MODE, 8'(MODE_RESERVED));
    set_reg(REG_SKIP_PERIOD, 8'd0);
    set_reg(REG_SKIP_INDEX, 8'd4);
    set_reg(REG_DEST_COUNT, 8'd0);
    stage(tick_item(64'd1, ALL_ONES, ALL_ONES));
    stage(tick_item(64'd2, 64'hFFFF_FFFF_FFFF_FFFE, '0));
    stage(tick_item(64'd2, 64'd1, '0));
    stage(tick_item(64'd5, '0, ALL_ONES));
    issue(batch);
    wait_idle();

    // largest period and index, count above the limit, request first
    set_reg(REG_SHAPER_MODE, 8'(MODE_SKIP));
    set_reg(REG_SKIP_PERIOD, 8'd255);
    set_reg(REG_SKIP_INDEX, 8'd63);
    set_reg(REG_DEST_COUNT, 8'd127);
    set_reg(REG_RESPONSE_PRIORITY_ON, 8'd0);
    stage(grant_item(CHAN_REQ, 6'd50));
    stage(tick_item(64'd63, ALL_ONES, ALL_ONES));
    stage(tick_item(ALL_ONES, ALL_ONES, ALL_ONES));
    issue(batch);
    wait_idle();

    // pointer beyond a smaller count, grant outside the count, zero bound
    set_reg(REG_DEST_COUNT, 8'd8);
    set_reg(REG_RESPONSE_BOUND, 8'd0);
    set_reg(REG_RESPONSE_PRIORITY_ON, 8'd1);
    stage(tick_item(64'd0, 64'h42, ALL_ONES));
    stage(grant_item(CHAN_RSP, 6'd60));
    stage(tick_item(64'd1, '0, 64'h14));
    issue(batch);
    wait_idle();

    // long response streak saturates the consecutive count
    set_reg(REG_DEST_COUNT, 8'd64);
    set_reg(REG_RESPONSE_BOUND, 8'd255);
    repeat (260) stage(grant_item(CHAN_RSP, rand_dest()));
    stage(tick_item(64'd1, ALL_ONES, ALL_ONES));
    stage(grant_item(CHAN_REQ, 6'd0));
    stage(tick_item(64'd1, ALL_ONES, ALL_ONES));
    issue(batch);
    wait_idle();

    while (random_sent < 400) begin
      randomize_regs();
      phase_len = $urandom_range(30, 70);
      while (batch.size() < phase_len) begin
        case ($urandom_range(0, 3))
          0: begin
            // response grants in a row, then a tick with work on both channels
            k = $urandom_range(1, 8);
            repeat (k) stage(grant_item(CHAN_RSP, rand_dest()));
            stage(tick_item(rand_cycle(), rand_mask() | (64'd1 << rand_dest()),
                            rand_mask() | (64'd1 << rand_dest())));
          end
          1: begin
            stage(tick_item(rand_cycle(), rand_mask(), rand_mask()));
            stage(grant_item(1'($urandom_range(0, 1)), rand_dest()));
          end
          default: stage(random_item());
        endcase
      end
      random_sent += batch.size();
      issue(batch);
      if (settings_used % 4 == 2) begin
        repeat (40) @(negedge clk);
        holdoff_request = 1'b1;
      end
      wait_idle();
    end

    repeat (30) @(posedge clk);
    $display("checked %0d result transactions: %0d ticks (%0d with a head), %0d grants",
             picks_checked, ticks_sent, heads_seen, grants_sent);
    $display("register settings used: %0d, receiver holdoffs of %0d cycles included",
             settings_used, HOLDOFF_CYCLES);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ishs_pkg.sv
design/ishs_rem.sv
design/ishs_pick.sv
design/injection_shaper_head_select.sv
tb/injection_shaper_head_select_test.sv
